FILE: hdl/sfscc_pkg.sv
// ============================================================================
// sfscc_pkg: shared types and constants of the stereo curve compressor
// Payload structs, fixed-point formats, register map and the sine table
// generator used at elaboration time.
// ============================================================================
`default_nettype none

package sfscc_pkg;

    // Sample format and datapath widths.
    localparam int SAMPLE_WIDTH = 24;
    localparam int FRAC         = SAMPLE_WIDTH - 1;
    localparam int XW           = SAMPLE_WIDTH + 8;   // running sample, about +-256
    localparam int MA           = XW;                 // multiplier operand A
    localparam int MB           = 32;                 // multiplier operand B
    localparam int PW           = MA + MB;            // product
    localparam int DN           = XW + 20;            // divider dividend and quotient
    localparam int DV           = 22;                 // divider divisor
    localparam int CNT_W        = $clog2(DN + 1);
    localparam int GAIN_W       = 24;                 // Q4.20 gain
    localparam int GSW          = 27;                 // gain update sum
    localparam int RATE_W       = 31;                 // Q0.32 step rate
    localparam int ROM_W        = 22;                 // Q1.20 sine entry
    localparam int T_W          = 24;                 // trigger after floor
    localparam int TRAW_W       = 26;                 // trigger before floor
    localparam int COMP_W       = 22;                 // compress, Q2.20 unsigned
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    // Register map, indexed by paddr[3:2].
    typedef enum logic [1:0] {
        REG_BOOST      = 2'd0,
        REG_MIX        = 2'd1,
        REG_RATE_SCALE = 2'd2
    } cfg_reg_t;

    localparam logic [16:0] BOOST_RESET = 17'd32768;
    localparam logic [16:0] MIX_RESET   = 17'd65536;
    localparam logic [15:0] RATE_RESET  = 16'd4096;
    localparam logic [16:0] Q16_ONE     = 17'd65536;
    localparam logic [15:0] RATE_MIN    = 16'd1024;
    localparam logic [15:0] RATE_MAX    = 16'd32768;

    // Fixed-point constants.
    localparam logic [COMP_W-1:0]        ONE_Q20       = COMP_W'(1 << 20);
    localparam logic signed [GAIN_W-1:0] GAIN_RESET    = GAIN_W'(2 << 20);
    localparam logic signed [GSW-1:0]    GAIN_FLOOR    = -GSW'(8 << 20);
    localparam logic signed [TRAW_W-1:0] TRIG_FLOOR    = -TRAW_W'(4404019);
    localparam logic signed [PW-1:0]     X_HI          = (PW'(1) << (XW - 1)) - PW'(1);
    localparam logic signed [PW-1:0]     X_LO          = -(PW'(1) << (XW - 1));
    localparam logic [XW-1:0]            X_UNIT        = XW'(1) << FRAC;
    localparam longint                   LIM_VAL       = (longint'(999) << FRAC) / 1000;
    localparam logic signed [PW:0]       OUT_LIM       = (PW + 1)'(LIM_VAL);
    localparam logic [3:0]               RATE_STEP_MUL = 4'd10;
    localparam logic [DV-1:0]            RATE_DIV_BASE = DV'(13);

    // Q3.30 angle constants of the sine table.
    localparam longint unsigned Q30_ONE       = 64'd1 << 30;
    localparam longint unsigned Q30_THETA_MAX = 64'd5046586573;
    localparam longint unsigned Q30_PI        = 64'd3373259426;
    localparam longint unsigned Q30_HALF_PI   = 64'd1686629713;

    // Input and result payloads.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_left;
        logic signed [SAMPLE_WIDTH-1:0] sample_right;
    } in_payload_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_left;
        logic signed [SAMPLE_WIDTH-1:0] out_right;
    } out_payload_t;

    // Sine of an angle in [0, pi/2], Q2.30 in and out, by a Taylor series.
    function automatic longint unsigned sine_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    // One sine table entry: sin(4.7 * idx / 2^bits) in Q1.20, magnitude rounded half up.
    function automatic logic signed [ROM_W-1:0] sine_entry(int bits, int idx);
        longint unsigned th;
        longint unsigned mag;
        logic            neg;
        th  = (Q30_THETA_MAX * 64'(idx)) >> bits;
        neg = 1'b0;
        if (th <= Q30_HALF_PI) begin
            mag = sine_q30(th);
        end else if (th <= Q30_PI) begin
            mag = sine_q30(Q30_PI - th);
        end else begin
            mag = sine_q30(th - Q30_PI);
            neg = 1'b1;
        end
        mag = (mag + 64'd512) >> 10;
        return neg ? -ROM_W'(mag) : ROM_W'(mag);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/stereo_five_stage_curve_compressor_core.sv
// ============================================================================
// stereo_five_stage_curve_compressor_core: stereo curve compressor
// Runs each channel through a chain of self-adjusting gain stages, divides by
// the compress factor, mixes with the dry sample and clips to +-0.999.
// ============================================================================
// Usage:
// - Input channel s_valid/s_ready/s_data carries one stereo pair per request.
//   Result channel m_valid/m_ready/m_data returns one processed pair each.
// - Configuration goes through the APB port: boost at 0x0, mix at 0x4 and
//   rate_scale at 0x8. Write only while the block is idle.
// - After reset, and after each register write, the block derives compress
//   and the stage rates; s_ready stays low meanwhile.
// - Left and right pass one after the other through a single shared
//   multiplier and a radix-2 divider; the divider's 52 steps per channel
//   take the largest share of the processing time.
// - One pair is processed at a time. A finished result sits in the output
//   register, and the next pair is accepted while it waits; a stalled
//   receiver holds the block only when the next result is ready to leave.
// - Reset restores the registers and all stage gains to 2.0.
// ============================================================================
`default_nettype none

module stereo_five_stage_curve_compressor_core #(
    parameter int STAGES          = 5,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire sfscc_pkg::in_payload_t            s_data,
    // Result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output sfscc_pkg::out_payload_t                m_data,
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sfscc_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [sfscc_pkg::PDATA_W-1:0]     pwdata,
    output logic [sfscc_pkg::PDATA_W-1:0]          prdata,
    output logic                                   pready
);

    localparam int XW     = sfscc_pkg::XW;
    localparam int MA     = sfscc_pkg::MA;
    localparam int MB     = sfscc_pkg::MB;
    localparam int PW     = sfscc_pkg::PW;
    localparam int DN     = sfscc_pkg::DN;
    localparam int DV     = sfscc_pkg::DV;
    localparam int CNT_W  = sfscc_pkg::CNT_W;
    localparam int GAIN_W = sfscc_pkg::GAIN_W;
    localparam int GSW    = sfscc_pkg::GSW;
    localparam int RATE_W = sfscc_pkg::RATE_W;
    localparam int ROM_W  = sfscc_pkg::ROM_W;
    localparam int T_W    = sfscc_pkg::T_W;
    localparam int TRAW_W = sfscc_pkg::TRAW_W;
    localparam int COMP_W = sfscc_pkg::COMP_W;
    localparam int FRAC   = sfscc_pkg::FRAC;
    localparam int SW     = sfscc_pkg::SAMPLE_WIDTH;

    localparam int FS       = FRAC - SINE_TABLE_BITS;   // interpolation fraction bits
    localparam int IB       = SINE_TABLE_BITS + 1;      // table index bits
    localparam int TAB_N    = (1 << SINE_TABLE_BITS) + 1;
    localparam int SB       = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int GB       = $clog2(2 * STAGES);
    localparam logic [IB-1:0] LAST_IDX  = IB'(1 << SINE_TABLE_BITS);
    localparam logic [SB-1:0] LAST_STG  = SB'(STAGES - 1);

    // Sine table, built at elaboration.
    typedef logic signed [ROM_W-1:0] sine_rom_t [TAB_N];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < TAB_N; i++) begin
            rom[i] = sfscc_pkg::sine_entry(SINE_TABLE_BITS, i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    typedef enum logic [4:0] {
        S_IDLE,
        S_DV_BSQ,
        S_DV_COMP,
        S_DV_CSQ,
        S_DV_R0,
        S_DV_R0W,
        S_DV_RKM,
        S_DV_RKD,
        S_DV_RKW,
        S_LOAD,
        S_XMUL,
        S_XSAT,
        S_ROMA,
        S_ROMB,
        S_INTERP,
        S_TRIG,
        S_RMUL,
        S_GAIN,
        S_QDIV,
        S_QDIVW,
        S_WMUL,
        S_DMUL,
        S_MIX,
        S_DONE
    } state_t;

    state_t                        state_reg;
    logic                          derive_pend_reg;
    logic [16:0]                   boost_reg;
    logic [16:0]                   mix_reg;
    logic [15:0]                   rate_scale_reg;
    logic [COMP_W-1:0]             compress_reg;
    logic [RATE_W-1:0]             rates_reg [STAGES];
    logic signed [GAIN_W-1:0]      gains_reg [2 * STAGES];
    sfscc_pkg::in_payload_t        in_reg;
    logic                          ch_reg;
    logic [SB-1:0]                 stage_reg;
    logic signed [XW-1:0]          x_reg;
    logic signed [SW-1:0]          dry_reg;
    logic [IB-1:0]                 idx_reg;
    logic [FS-1:0]                 fr_reg;
    logic signed [ROM_W-1:0]       rom_a_reg;
    logic signed [ROM_W-1:0]       rom_q_reg;
    logic signed [T_W-1:0]         t_reg;
    logic                          neg_reg;
    logic signed [XW-1:0]          q_reg;
    logic signed [PW-1:0]          acc_reg;
    logic signed [SW-1:0]          res_left_reg;
    logic signed [SW-1:0]          res_right_reg;
    logic                          m_valid_reg;
    sfscc_pkg::out_payload_t       m_data_reg;

    logic signed [PW-1:0]          prod_reg;
    logic signed [MA-1:0]          mul_a;
    logic signed [MB-1:0]          mul_b;

    logic [DN-1:0]                 div_quo_reg;
    logic [DV-1:0]                 div_rem_reg;
    logic [DV-1:0]                 div_den_reg;
    logic [CNT_W-1:0]              div_cnt_reg;
    logic                          div_start;
    logic [DN-1:0]                 div_dividend;
    logic [DV-1:0]                 div_divisor;
    logic [DV:0]                   div_shift;
    logic [DV:0]                   div_diff;
    logic                          div_ge;

    logic                          cfg_write;
    logic                          cfg_hit;
    logic [16:0]                   wdata17;
    logic [15:0]                   wdata16;
    logic [GB-1:0]                 gain_idx;
    logic signed [GAIN_W-1:0]      gain_cur;
    logic [RATE_W-1:0]             rate_cur;
    logic [XW-1:0]                 x_abs;
    logic [XW-1:0]                 x_lim;
    logic [IB-1:0]                 rom_addr;
    logic signed [ROM_W:0]         rom_diff;
    logic signed [PW-1:0]          x_shift;
    logic signed [XW-1:0]          x_sat;
    logic signed [PW-1:0]          interp;
    logic signed [TRAW_W-1:0]      t_raw;
    logic signed [TRAW_W-1:0]      t_scaled;
    logic signed [TRAW_W-1:0]      t_floor;
    logic signed [GSW-1:0]         g_step;
    logic signed [GSW-1:0]         g_sum;
    logic signed [GSW-1:0]         g_new;
    logic signed [PW:0]            mix_sum;
    logic signed [PW:0]            mix_sh;
    logic signed [PW:0]            mix_clip;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == S_IDLE) && !derive_pend_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration write decode and saturation.
    assign cfg_write = psel && penable && pwrite;
    assign cfg_hit   = cfg_write && (sfscc_pkg::cfg_reg_t'(paddr[3:2]) inside
                       {sfscc_pkg::REG_BOOST, sfscc_pkg::REG_MIX, sfscc_pkg::REG_RATE_SCALE});
    assign wdata17   = (pwdata[16:0] > sfscc_pkg::Q16_ONE) ? sfscc_pkg::Q16_ONE : pwdata[16:0];
    always_comb begin
        wdata16 = pwdata[15:0];
        if (pwdata[15:0] < sfscc_pkg::RATE_MIN) begin
            wdata16 = sfscc_pkg::RATE_MIN;
        end else if (pwdata[15:0] > sfscc_pkg::RATE_MAX) begin
            wdata16 = sfscc_pkg::RATE_MAX;
        end
    end

    // Register read-back.
    always_comb begin
        case (sfscc_pkg::cfg_reg_t'(paddr[3:2]))
            sfscc_pkg::REG_BOOST:      prdata = 32'(boost_reg);
            sfscc_pkg::REG_MIX:        prdata = 32'(mix_reg);
            sfscc_pkg::REG_RATE_SCALE: prdata = 32'(rate_scale_reg);
            default:                   prdata = '0;
        endcase
    end

    // Current stage gain and rate; the first stage uses the slowest rate.
    assign gain_idx = ch_reg ? (GB'(STAGES) + GB'(stage_reg)) : GB'(stage_reg);
    assign gain_cur = gains_reg[gain_idx];
    assign rate_cur = rates_reg[LAST_STG - stage_reg];

    // Magnitude of the running sample, limited to 1.0, split into index and fraction.
    assign x_abs = x_reg[XW-1] ? XW'(-x_reg) : XW'(x_reg);
    assign x_lim = (x_abs > sfscc_pkg::X_UNIT) ? sfscc_pkg::X_UNIT : x_abs;

    always_comb begin
        case (state_reg)
            S_ROMA:  rom_addr = x_lim[FRAC:FS];
            S_ROMB:  rom_addr = (idx_reg == LAST_IDX) ? LAST_IDX : idx_reg + IB'(1);
            default: rom_addr = idx_reg;
        endcase
    end

    // Sine table with registered read.
    always_ff @(posedge aclk) begin
        rom_q_reg <= SINE_ROM[rom_addr];
    end

    assign rom_diff = (ROM_W + 1)'(rom_q_reg) - (ROM_W + 1)'(rom_a_reg);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DV_BSQ: begin
                mul_a = MA'(boost_reg);
                mul_b = MB'(boost_reg);
            end
            S_DV_CSQ: begin
                mul_a = MA'(compress_reg);
                mul_b = MB'(compress_reg);
            end
            S_DV_RKM: begin
                mul_a = MA'(sfscc_pkg::RATE_STEP_MUL);
                mul_b = MB'(rates_reg[stage_reg - SB'(1)]);
            end
            S_XMUL: begin
                mul_a = x_reg;
                mul_b = MB'(gain_cur);
            end
            S_INTERP: begin
                mul_a = MA'(rom_diff);
                mul_b = MB'(fr_reg);
            end
            S_RMUL: begin
                mul_a = MA'(t_reg);
                mul_b = MB'(rate_cur);
            end
            S_WMUL: begin
                mul_a = q_reg;
                mul_b = MB'(mix_reg);
            end
            S_DMUL: begin
                mul_a = MA'(dry_reg);
                mul_b = MB'(sfscc_pkg::Q16_ONE - mix_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Registered product.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Divider operand selection.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = prod_reg[DN-1:0];
        div_divisor  = DV'({rate_scale_reg, 2'b00});
        case (state_reg)
            S_DV_R0: begin
                div_start = 1'b1;
            end
            S_DV_RKD: begin
                div_start   = 1'b1;
                div_divisor = sfscc_pkg::RATE_DIV_BASE + DV'(stage_reg);
            end
            S_QDIV: begin
                div_start    = 1'b1;
                div_dividend = {x_abs, 20'b0};
                div_divisor  = DV'(compress_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Radix-2 restoring divider, one quotient bit per cycle.
    assign div_shift = {div_rem_reg, div_quo_reg[DN-1]};
    assign div_diff  = div_shift - {1'b0, div_den_reg};
    assign div_ge    = (div_shift >= {1'b0, div_den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (div_start) begin
            div_quo_reg <= div_dividend;
            div_rem_reg <= '0;
            div_den_reg <= div_divisor;
            div_cnt_reg <= CNT_W'(DN);
        end else if (div_cnt_reg != '0) begin
            div_quo_reg <= {div_quo_reg[DN-2:0], div_ge};
            div_rem_reg <= div_ge ? div_diff[DV-1:0] : div_shift[DV-1:0];
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
    end

    // Stage product, floored and saturated.
    assign x_shift = prod_reg >>> 20;
    always_comb begin
        if (x_shift > sfscc_pkg::X_HI) begin
            x_sat = XW'(sfscc_pkg::X_HI);
        end else if (x_shift < sfscc_pkg::X_LO) begin
            x_sat = XW'(sfscc_pkg::X_LO);
        end else begin
            x_sat = x_shift[XW-1:0];
        end
    end

    // Trigger: interpolated sine, negative side scaled by 8 and floored.
    assign interp   = prod_reg >>> FS;
    assign t_raw    = (idx_reg == LAST_IDX) ? TRAW_W'(rom_a_reg)
                                            : TRAW_W'(rom_a_reg) + $signed(interp[TRAW_W-1:0]);
    assign t_scaled = t_raw[TRAW_W-1] ? (t_raw <<< 3) : t_raw;
    assign t_floor  = (t_scaled < sfscc_pkg::TRIG_FLOOR) ? sfscc_pkg::TRIG_FLOOR : t_scaled;

    // Gain update, capped at compress and floored at -8.
    assign g_step = prod_reg[32 +: GSW];
    assign g_sum  = GSW'(gain_cur) + g_step;
    always_comb begin
        if (g_sum > $signed(GSW'(compress_reg))) begin
            g_new = GSW'(compress_reg);
        end else if (g_sum < sfscc_pkg::GAIN_FLOOR) begin
            g_new = sfscc_pkg::GAIN_FLOOR;
        end else begin
            g_new = g_sum;
        end
    end

    // Wet and dry mix, then the output clip.
    assign mix_sum = (PW + 1)'(acc_reg) + (PW + 1)'(prod_reg);
    assign mix_sh  = mix_sum >>> 16;
    always_comb begin
        if (mix_sh > sfscc_pkg::OUT_LIM) begin
            mix_clip = sfscc_pkg::OUT_LIM;
        end else if (mix_sh < -sfscc_pkg::OUT_LIM) begin
            mix_clip = -sfscc_pkg::OUT_LIM;
        end else begin
            mix_clip = mix_sh;
        end
    end

    // Sequencer, registers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            derive_pend_reg <= 1'b1;
            boost_reg       <= sfscc_pkg::BOOST_RESET;
            mix_reg         <= sfscc_pkg::MIX_RESET;
            rate_scale_reg  <= sfscc_pkg::RATE_RESET;
            m_valid_reg     <= 1'b0;
            ch_reg          <= 1'b0;
            stage_reg       <= '0;
            for (int i = 0; i < 2 * STAGES; i++) begin
                gains_reg[i] <= sfscc_pkg::GAIN_RESET;
            end
        end else begin
            // The output register empties on a handshake unless a new result replaces it.
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (derive_pend_reg) begin
                        state_reg <= S_DV_BSQ;
                    end else if (s_valid) begin
                        in_reg    <= s_data;
                        ch_reg    <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                // Derive compress = 1 + boost^2 and the stage rates.
                S_DV_BSQ: begin
                    state_reg <= S_DV_COMP;
                end
                S_DV_COMP: begin
                    compress_reg <= sfscc_pkg::ONE_Q20 + prod_reg[33:12];
                    state_reg    <= S_DV_CSQ;
                end
                S_DV_CSQ: begin
                    state_reg <= S_DV_R0;
                end
                S_DV_R0: begin
                    state_reg <= S_DV_R0W;
                end
                S_DV_R0W: begin
                    if (div_cnt_reg == '0) begin
                        rates_reg[0] <= div_quo_reg[RATE_W-1:0];
                        stage_reg    <= SB'(1);
                        state_reg    <= (STAGES == 1) ? S_IDLE : S_DV_RKM;
                    end
                end
                S_DV_RKM: begin
                    state_reg <= S_DV_RKD;
                end
                S_DV_RKD: begin
                    state_reg <= S_DV_RKW;
                end
                S_DV_RKW: begin
                    if (div_cnt_reg == '0) begin
                        rates_reg[stage_reg] <= div_quo_reg[RATE_W-1:0];
                        if (stage_reg == LAST_STG) begin
                            state_reg <= S_IDLE;
                        end else begin
                            stage_reg <= stage_reg + SB'(1);
                            state_reg <= S_DV_RKM;
                        end
                    end
                end
                // Per channel: load the dry sample.
                S_LOAD: begin
                    x_reg     <= ch_reg ? XW'(in_reg.sample_right) : XW'(in_reg.sample_left);
                    dry_reg   <= ch_reg ? in_reg.sample_right : in_reg.sample_left;
                    stage_reg <= '0;
                    state_reg <= S_XMUL;
                end
                S_XMUL: begin
                    state_reg <= S_XSAT;
                end
                S_XSAT: begin
                    x_reg     <= x_sat;
                    state_reg <= S_ROMA;
                end
                S_ROMA: begin
                    idx_reg   <= x_lim[FRAC:FS];
                    fr_reg    <= x_lim[FS-1:0];
                    state_reg <= S_ROMB;
                end
                S_ROMB: begin
                    rom_a_reg <= rom_q_reg;
                    state_reg <= S_INTERP;
                end
                S_INTERP: begin
                    state_reg <= S_TRIG;
                end
                S_TRIG: begin
                    t_reg     <= T_W'(t_floor);
                    state_reg <= S_RMUL;
                end
                S_RMUL: begin
                    state_reg <= S_GAIN;
                end
                S_GAIN: begin
                    gains_reg[gain_idx] <= GAIN_W'(g_new);
                    if (stage_reg == LAST_STG) begin
                        state_reg <= S_QDIV;
                    end else begin
                        stage_reg <= stage_reg + SB'(1);
                        state_reg <= S_XMUL;
                    end
                end
                // Divide by compress, truncating toward zero.
                S_QDIV: begin
                    neg_reg   <= x_reg[XW-1];
                    state_reg <= S_QDIVW;
                end
                S_QDIVW: begin
                    if (div_cnt_reg == '0) begin
                        q_reg     <= neg_reg ? -XW'(div_quo_reg[XW-1:0])
                                             : XW'(div_quo_reg[XW-1:0]);
                        state_reg <= S_WMUL;
                    end
                end
                S_WMUL: begin
                    state_reg <= S_DMUL;
                end
                S_DMUL: begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_MIX;
                end
                S_MIX: begin
                    if (!ch_reg) begin
                        res_left_reg <= mix_clip[SW-1:0];
                        ch_reg       <= 1'b1;
                        state_reg    <= S_LOAD;
                    end else begin
                        res_right_reg <= mix_clip[SW-1:0];
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.out_left  <= res_left_reg;
                        m_data_reg.out_right <= res_right_reg;
                        m_valid_reg          <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Register writes.
            if (cfg_write) begin
                case (sfscc_pkg::cfg_reg_t'(paddr[3:2]))
                    sfscc_pkg::REG_BOOST: begin
                        boost_reg <= wdata17;
                    end
                    sfscc_pkg::REG_MIX: begin
                        mix_reg <= wdata17;
                    end
                    sfscc_pkg::REG_RATE_SCALE: begin
                        rate_scale_reg <= wdata16;
                    end
                    default: begin
                    end
                endcase
            end

            // Any register write reruns the derivation; leaving idle starts it.
            if (cfg_hit) begin
                derive_pend_reg <= 1'b1;
            end else if (state_reg == S_IDLE) begin
                derive_pend_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_stereo_five_stage_curve_compressor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stereo curve compressor core regression
// Drives stereo pairs through the valid/ready input channel under several
// register settings and idle patterns. A bit-exact predictor of the gain
// chain, divide, mix and clip works out each pair's result, and the
// monitor compares every result with it.
// ----------------------------------------------------------------------------
module tb_stereo_five_stage_curve_compressor_core;

    localparam int NSTG      = 5;
    localparam int TBITS     = 10;
    localparam int SWID      = sfscc_pkg::SAMPLE_WIDTH;
    localparam int FRB       = sfscc_pkg::FRAC;
    localparam int AW        = sfscc_pkg::PADDR_W;
    localparam int DW        = sfscc_pkg::PDATA_W;
    localparam int TAB_LEN   = (1 << TBITS) + 1;
    localparam int FR_BITS   = FRB - TBITS;
    localparam longint TRIG_MIN  = -64'sd4404019;
    localparam longint GAIN_MIN  = -(64'sd8 <<< 20);
    localparam longint RUN_HI    = (64'sd1 <<< (FRB + 8)) - 1;
    localparam longint RUN_LO    = -(64'sd1 <<< (FRB + 8));
    localparam longint CLIP_LIM  = (64'sd999 <<< FRB) / 1000;
    localparam int PHASES    = 8;
    localparam int PHASE_REQ = 210;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    sfscc_pkg::in_payload_t  s_data = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    sfscc_pkg::out_payload_t m_data;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [AW-1:0]           paddr = '0;
    logic [DW-1:0]           pwdata = '0;
    logic [DW-1:0]           prdata;
    logic                    pready;

    stereo_five_stage_curve_compressor_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock generation.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predictor state: sine table, registers, derived values and gains.
    longint          sin_tab [TAB_LEN];
    longint          gain_q20 [2*NSTG];
    longint unsigned boost_q16;
    longint unsigned mix_q16;
    longint unsigned rate_q12;
    longint          compress_q20;
    longint unsigned step_rate [NSTG];

    sfscc_pkg::in_payload_t  pending_pairs [$];
    sfscc_pkg::out_payload_t expected_pairs [$];
    int  err_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  send_hold = 1'b0;

    // Sine over [0, pi/2] in Q2.30 by a nested series.
    function automatic longint unsigned series_sine(longint unsigned x);
        longint unsigned x2, acc;
        x2  = (x * x) >> 30;
        acc = sfscc_pkg::Q30_ONE - x2 / 110;
        acc = sfscc_pkg::Q30_ONE - ((x2 * acc) >> 30) / 72;
        acc = sfscc_pkg::Q30_ONE - ((x2 * acc) >> 30) / 42;
        acc = sfscc_pkg::Q30_ONE - ((x2 * acc) >> 30) / 20;
        acc = sfscc_pkg::Q30_ONE - ((x2 * acc) >> 30) / 6;
        return (x * acc) >> 30;
    endfunction

    function automatic void build_sine_table();
        longint unsigned ang, mag;
        bit neg;
        for (int i = 0; i < TAB_LEN; i++) begin
            ang = (sfscc_pkg::Q30_THETA_MAX * longint'(i)) >> TBITS;
            neg = 1'b0;
            if (ang <= sfscc_pkg::Q30_HALF_PI) begin
                mag = series_sine(ang);
            end else if (ang <= sfscc_pkg::Q30_PI) begin
                mag = series_sine(sfscc_pkg::Q30_PI - ang);
            end else begin
                mag = series_sine(ang - sfscc_pkg::Q30_PI);
                neg = 1'b1;
            end
            mag = (mag + 512) >> 10;
            sin_tab[i] = neg ? -longint'(mag) : longint'(mag);
        end
    endfunction

    // Compress factor and the per-stage step rates.
    function automatic void derive_rates();
        longint unsigned c2;
        compress_q20 = (64'sd1 <<< 20) + longint'((boost_q16 * boost_q16) >> 12);
        c2 = longint'(compress_q20) * longint'(compress_q20);
        step_rate[0] = c2 / (rate_q12 * 4);
        for (int k = 1; k < NSTG; k++) begin
            step_rate[k] = step_rate[k-1] * 10 / longint'(13 + k);
        end
    endfunction

    // Register write as the block sees it, with saturation.
    function automatic void apply_reg_write(int idx, longint unsigned val);
        case (idx)
            sfscc_pkg::REG_BOOST: begin
                val = val & 64'h1FFFF;
                boost_q16 = (val > 65536) ? 65536 : val;
            end
            sfscc_pkg::REG_MIX: begin
                val = val & 64'h1FFFF;
                mix_q16 = (val > 65536) ? 65536 : val;
            end
            sfscc_pkg::REG_RATE_SCALE: begin
                val = val & 64'hFFFF;
                if (val < sfscc_pkg::RATE_MIN) val = sfscc_pkg::RATE_MIN;
                if (val > sfscc_pkg::RATE_MAX) val = sfscc_pkg::RATE_MAX;
                rate_q12 = val;
            end
            default: return;
        endcase
        derive_rates();
    endfunction

    // Trigger from the running sample: interpolated sine, shaped when negative.
    function automatic longint stage_trigger(longint x);
        longint u, idx, fr, tv, a, b;
        u = (x < 0) ? -x : x;
        if (u > (64'sd1 <<< FRB)) u = 64'sd1 <<< FRB;
        idx = u >>> FR_BITS;
        fr  = u & ((64'sd1 <<< FR_BITS) - 1);
        if (idx >= TAB_LEN - 1) begin
            tv = sin_tab[TAB_LEN-1];
        end else begin
            a  = sin_tab[idx];
            b  = sin_tab[idx+1];
            tv = a + (((b - a) * fr) >>> FR_BITS);
        end
        if (tv < 0) tv = tv * 8;
        if (tv < TRIG_MIN) tv = TRIG_MIN;
        return tv;
    endfunction

    // One channel through the gain chain, divide, mix and clip.
    function automatic longint compress_channel(longint dry, int base);
        longint x, g;
        x = dry;
        for (int i = 0; i < NSTG; i++) begin
            g = gain_q20[base+i];
            x = (x * g) >>> 20;
            if (x > RUN_HI) x = RUN_HI;
            if (x < RUN_LO) x = RUN_LO;
            g = g + ((stage_trigger(x) * longint'(step_rate[NSTG-1-i])) >>> 32);
            if (g > compress_q20) g = compress_q20;
            if (g < GAIN_MIN) g = GAIN_MIN;
            gain_q20[base+i] = g;
        end
        x = (x * (64'sd1 <<< 20)) / compress_q20;
        x = (x * longint'(mix_q16) + dry * (65536 - longint'(mix_q16))) >>> 16;
        if (x > CLIP_LIM) x = CLIP_LIM;
        if (x < -CLIP_LIM) x = -CLIP_LIM;
        return x;
    endfunction

    function automatic sfscc_pkg::out_payload_t predict_pair(sfscc_pkg::in_payload_t req);
        sfscc_pkg::out_payload_t res;
        res.out_left  = SWID'(compress_channel(longint'(req.sample_left), 0));
        res.out_right = SWID'(compress_channel(longint'(req.sample_right), NSTG));
        return res;
    endfunction

    task automatic report_mismatch(string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Random sample: full range, scaled down, near positive full scale or just below zero, or near zero.
    function automatic logic [SWID-1:0] rand_sample();
        logic signed [SWID-1:0] v;
        v = SWID'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1: v = v >>> $urandom_range(1, 20);
            2: v = v[SWID-1] ? v | 24'hFF0000 : v | 24'h7F0000;
            default: v = v >>> 21;
        endcase
        return v;
    endfunction

    // Request driver: feeds pending pairs and records each accepted one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_pairs.push_back(predict_pair(s_data));
            end
            if (!s_valid || s_ready) begin
                if (!send_hold && pending_pairs.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_pairs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pairs.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    sfscc_pkg::out_payload_t want;
                    want = expected_pairs.pop_front();
                    if (m_data.out_left !== want.out_left)
                        report_mismatch($sformatf("out_left %0d, expected %0d",
                                        m_data.out_left, want.out_left));
                    if (m_data.out_right !== want.out_right)
                        report_mismatch($sformatf("out_right %0d, expected %0d",
                                        m_data.out_right, want.out_right));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic cfg_write(int idx, logic [DW-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(idx * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg_write(idx, val);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_pairs.size() != 0 || s_valid || expected_pairs.size() != 0);
    endtask

    task automatic push_pair(logic [SWID-1:0] l, logic [SWID-1:0] r);
        sfscc_pkg::in_payload_t p;
        p.sample_left  = l;
        p.sample_right = r;
        pending_pairs.push_back(p);
    endtask

    // Stimulus: directed pairs, then register settings with random traffic.
    initial begin
        boost_q16 = sfscc_pkg::BOOST_RESET;
        mix_q16   = sfscc_pkg::MIX_RESET;
        rate_q12  = sfscc_pkg::RATE_RESET;
        for (int i = 0; i < 2*NSTG; i++) gain_q20[i] = 64'sd2 <<< 20;
        build_sine_table();
        derive_rates();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes, zero, tiny values and full-scale bursts that saturate.
        push_pair(24'h000000, 24'h000000);
        push_pair(24'h7FFFFF, 24'h800000);
        push_pair(24'h800000, 24'h7FFFFF);
        push_pair(24'h000001, 24'hFFFFFF);
        push_pair(24'hFFFFFF, 24'h000001);
        push_pair(24'h400000, 24'hC00000);
        push_pair(24'h100000, 24'hF00000);
        push_pair(24'h002000, 24'hFFE000);
        for (int i = 0; i < 6; i++) push_pair(24'h7FFFFF, 24'h7FFFFF);
        for (int i = 0; i < 6; i++) push_pair(24'h800000, 24'h800000);
        push_pair(24'h555555, 24'hAAAAAA);
        push_pair(24'hAAAAAA, 24'h555555);
        push_pair(24'h000000, 24'h000000);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                repeat (300) @(posedge aclk);
                case (ph)
                    1: begin
                        cfg_write(sfscc_pkg::REG_BOOST, 32'd0);
                        cfg_write(sfscc_pkg::REG_MIX, 32'd65536);
                        cfg_write(sfscc_pkg::REG_RATE_SCALE, 32'd1024);
                    end
                    2: begin
                        cfg_write(sfscc_pkg::REG_BOOST, 32'd65536);
                        cfg_write(sfscc_pkg::REG_MIX, 32'd0);
                        cfg_write(sfscc_pkg::REG_RATE_SCALE, 32'd32768);
                    end
                    3: begin
                        cfg_write(sfscc_pkg::REG_BOOST, 32'hFFFF_FFFF);
                        cfg_write(sfscc_pkg::REG_MIX, 32'd32768);
                        cfg_write(sfscc_pkg::REG_RATE_SCALE, 32'd0);
                    end
                    4: begin
                        cfg_write(sfscc_pkg::REG_BOOST, $urandom_range(0, 65536));
                        cfg_write(sfscc_pkg::REG_MIX, 32'h0001_FFFF);
                        cfg_write(sfscc_pkg::REG_RATE_SCALE, 32'hFFFF_FFFF);
                    end
                    5: begin
                        cfg_write(sfscc_pkg::REG_BOOST, 32'd12345);
                        cfg_write(sfscc_pkg::REG_MIX, 32'd40000);
                        cfg_write(sfscc_pkg::REG_RATE_SCALE, 32'd4096);
                        cfg_write(3, $urandom);
                    end
                    6: begin
                        cfg_write(sfscc_pkg::REG_BOOST, $urandom_range(0, 65536));
                        cfg_write(sfscc_pkg::REG_MIX, $urandom_range(0, 65536));
                        cfg_write(sfscc_pkg::REG_RATE_SCALE, $urandom_range(1024, 32768));
                    end
                    default: begin
                        cfg_write(sfscc_pkg::REG_BOOST, 32'd65536);
                        cfg_write(sfscc_pkg::REG_MIX, 32'd65536);
                        cfg_write(sfscc_pkg::REG_RATE_SCALE, 32'd1024);
                    end
                endcase
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int n = 0; n < PHASE_REQ; n++) push_pair(rand_sample(), rand_sample());
            // Hold the sender mid-phase until every result is back.
            if (ph == 3) begin
                repeat (2000) @(posedge aclk);
                send_hold = 1'b1;
                while (s_valid || expected_pairs.size() != 0) @(posedge aclk);
                send_hold = 1'b0;
            end
        end

        wait_drained();
        repeat (250) @(posedge aclk);
        if (err_count == 0) begin
            $display("stereo_five_stage_curve_compressor_core regression: pass");
        end else begin
            $display("stereo_five_stage_curve_compressor_core regression: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #60ms;
        $display("stereo_five_stage_curve_compressor_core regression: fail");
        $finish;
    end

endmodule
